FILE: design/atas_pkg.sv
package atas_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] CFG_DRIVE_PRESENT    = 3'd0;
    localparam logic [2:0] CFG_DRIVE_IS_ATA     = 3'd1;
    localparam logic [2:0] CFG_LBA_SUPPORTED    = 3'd2;
    localparam logic [2:0] CFG_SECTOR_BYTES     = 3'd3;
    localparam logic [2:0] CFG_CAPACITY_SECTORS = 3'd4;
    localparam logic [2:0] CFG_TRACK_SECTORS    = 3'd5;
    localparam logic [2:0] CFG_CYLINDER_HEADS   = 3'd6;
    localparam logic [2:0] CFG_TRANSFER_LIMIT   = 3'd7;

    localparam int CFG_DATA_W = 48;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_DRIVE   = 3'd1;
    localparam logic [2:0] ST_WRONG_TYPE = 3'd2;
    localparam logic [2:0] ST_BAD_SIZE   = 3'd3;
    localparam logic [2:0] ST_MISALIGNED = 3'd4;

    // Addressing modes
    localparam logic [1:0] MODE_CHS   = 2'd0;
    localparam logic [1:0] MODE_LBA28 = 2'd1;
    localparam logic [1:0] MODE_LBA48 = 2'd2;

    // ATA commands and device/head bits
    localparam logic [7:0] CMD_READ      = 8'h20;
    localparam logic [7:0] CMD_READ_EXT  = 8'h24;
    localparam logic [7:0] CMD_WRITE     = 8'h30;
    localparam logic [7:0] CMD_WRITE_EXT = 8'h34;
    localparam logic [7:0] DEV_BASE      = 8'hA0;
    localparam logic [7:0] DEV_SLAVE     = 8'h10;
    localparam logic [7:0] DEV_LBA       = 8'h40;

    typedef struct packed {
        logic        op;
        logic        drive_slave;
        logic [63:0] byte_offset;
        logic [31:0] byte_count;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [1:0] addr_mode;
        logic [7:0] command_byte;
        logic [7:0] device_head;
        logic [7:0] sector_count;
        logic [7:0] addr_byte0;
        logic [7:0] addr_byte1;
        logic [7:0] addr_byte2;
        logic [7:0] addr_byte3;
        logic [7:0] addr_byte4;
        logic [7:0] addr_byte5;
    } t_res;

    // Sideband after the sector divider
    typedef struct packed {
        logic        op;
        logic        slave;
    } t_sb1;

    // Sideband through the track divider; the sector can exceed 48 bits
    // when the last byte wraps
    typedef struct packed {
        logic [2:0]  status;
        logic        op;
        logic        slave;
        logic [7:0]  nsect;
        logic [63:0] sect;
    } t_sb2;

    // Sideband through the head divider
    typedef struct packed {
        logic [2:0]  status;
        logic        op;
        logic        slave;
        logic [7:0]  nsect;
        logic [63:0] sect;
        logic [5:0]  srem;
    } t_sb3;

endpackage

FILE: design/atas_stream_if.sv
interface atas_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/ata_taskfile_address_setup.sv
// ATA PIO task-file set-up. Each request item (read/write, master/slave,
// byte offset, byte count) yields one result item with status, addressing
// mode, command, device/head, sector count and six address bytes. The block
// is a 193-stage pipeline and takes one item every clock while the output
// is not stalled: 64 stages divide offset, count and last byte by the sector
// size, 64 divide the sector by the track length, 64 divide by the head count
// for CHS, and one output register holds the result. A stall at the output
// freezes the whole pipeline. Configuration may only be written while no item
// is in flight.
module ata_taskfile_address_setup (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [2:0]                         i_cfg_index,
    input  logic [atas_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    atas_stream_if.sink                        i_req,
    atas_stream_if.source                      o_res
);

    // Configuration registers
    logic        r_present, r_is_ata, r_lba;
    logic [16:0] r_sb;
    logic [47:0] r_cap;
    logic [5:0]  r_ts;
    logic [4:0]  r_ch;
    logic [8:0]  r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= 1'b0;
            r_is_ata  <= 1'b0;
            r_lba     <= 1'b0;
            r_sb      <= 17'd512;
            r_cap     <= '0;
            r_ts      <= 6'd63;
            r_ch      <= 5'd16;
            r_limit   <= 9'd255;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                atas_pkg::CFG_DRIVE_PRESENT:    r_present <= i_cfg_data[0];
                atas_pkg::CFG_DRIVE_IS_ATA:     r_is_ata  <= i_cfg_data[0];
                atas_pkg::CFG_LBA_SUPPORTED:    r_lba     <= i_cfg_data[0];
                atas_pkg::CFG_SECTOR_BYTES:     r_sb      <= i_cfg_data[16:0];
                atas_pkg::CFG_CAPACITY_SECTORS: r_cap     <= i_cfg_data[47:0];
                atas_pkg::CFG_TRACK_SECTORS:    r_ts      <= i_cfg_data[5:0];
                atas_pkg::CFG_CYLINDER_HEADS:   r_ch      <= i_cfg_data[4:0];
                atas_pkg::CFG_TRANSFER_LIMIT:   r_limit   <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Global advance: the pipeline moves unless the output item is stalled
    logic r_ov;
    logic en;
    assign en          = !r_ov || o_res.ready;
    assign i_req.ready = en;

    // Stage group 1: divide offset, count and last byte by the sector size
    logic [2:0][63:0] d1_in;
    logic [2:0][63:0] d1_q;
    logic [2:0][16:0] d1_r;
    logic             d1_v;
    atas_pkg::t_sb1   sb1_in, sb1_out;

    assign d1_in[0]       = i_req.payload.byte_offset;
    assign d1_in[1]       = {32'd0, i_req.payload.byte_count};
    assign d1_in[2]       = i_req.payload.byte_offset
                            + {32'd0, i_req.payload.byte_count} - 64'd1;
    assign sb1_in.op      = i_req.payload.op;
    assign sb1_in.slave   = i_req.payload.drive_slave;

    atas_div #(.NW(64), .DW(17), .LN(3), .SW($bits(atas_pkg::t_sb1))) u_div_sect (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_req.valid),
        .i_dividend (d1_in),
        .i_divisor  (r_sb),
        .i_side     (sb1_in),
        .o_valid    (d1_v),
        .o_quot     (d1_q),
        .o_rem      (d1_r),
        .o_side     (sb1_out)
    );

    // Checks in priority order
    logic [2:0] st1;
    always_comb begin
        if (!r_present) begin
            st1 = atas_pkg::ST_NO_DRIVE;
        end else if (!r_is_ata) begin
            st1 = atas_pkg::ST_WRONG_TYPE;
        end else if (r_sb == '0) begin
            st1 = atas_pkg::ST_BAD_SIZE;
        end else if (d1_r[1] != '0 || d1_q[1] > {55'd0, r_limit}
                     || d1_q[2] >= {16'd0, r_cap}) begin
            st1 = atas_pkg::ST_BAD_SIZE;
        end else if (d1_r[0] != '0) begin
            st1 = atas_pkg::ST_MISALIGNED;
        end else if (!r_lba && (r_ts == '0 || r_ch == '0)) begin
            st1 = atas_pkg::ST_BAD_SIZE;
        end else begin
            st1 = atas_pkg::ST_OK;
        end
    end

    // Stage group 2: sector / sectors per track
    atas_pkg::t_sb2   sb2_in, sb2_out;
    logic [0:0][63:0] d2_q;
    logic [0:0][5:0]  d2_r;
    logic             d2_v;

    assign sb2_in.status = st1;
    assign sb2_in.op     = sb1_out.op;
    assign sb2_in.slave  = sb1_out.slave;
    assign sb2_in.nsect  = d1_q[1][7:0];
    assign sb2_in.sect   = d1_q[0];

    atas_div #(.NW(64), .DW(6), .LN(1), .SW($bits(atas_pkg::t_sb2))) u_div_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (d1_v),
        .i_dividend (d1_q[0]),
        .i_divisor  (r_ts),
        .i_side     (sb2_in),
        .o_valid    (d2_v),
        .o_quot     (d2_q),
        .o_rem      (d2_r),
        .o_side     (sb2_out)
    );

    // Stage group 3: track index / heads gives cylinder and head
    atas_pkg::t_sb3   sb3_in, sb3_out;
    logic [0:0][63:0] d3_q;
    logic [0:0][4:0]  d3_r;
    logic             d3_v;

    assign sb3_in.status = sb2_out.status;
    assign sb3_in.op     = sb2_out.op;
    assign sb3_in.slave  = sb2_out.slave;
    assign sb3_in.nsect  = sb2_out.nsect;
    assign sb3_in.sect   = sb2_out.sect;
    assign sb3_in.srem   = d2_r[0];

    atas_div #(.NW(64), .DW(5), .LN(1), .SW($bits(atas_pkg::t_sb3))) u_div_head (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (d2_v),
        .i_dividend (d2_q),
        .i_divisor  (r_ch),
        .i_side     (sb3_in),
        .o_valid    (d3_v),
        .o_quot     (d3_q),
        .o_rem      (d3_r),
        .o_side     (sb3_out)
    );

    // Task-file assembly
    atas_pkg::t_res n_res, r_res;
    always_comb begin
        logic [63:0] sect;
        logic [5:0]  snum;
        sect  = sb3_out.sect;
        snum  = sb3_out.srem + 6'd1;
        n_res = '0;
        n_res.status       = sb3_out.status;
        n_res.sector_count = sb3_out.nsect;
        n_res.device_head  = atas_pkg::DEV_BASE
                             | (sb3_out.slave ? atas_pkg::DEV_SLAVE : 8'h00);
        if (!r_lba) begin
            n_res.addr_mode   = atas_pkg::MODE_CHS;
            n_res.device_head = n_res.device_head | {4'h0, d3_r[0][3:0]};
            n_res.addr_byte0  = {2'b00, snum};
            n_res.addr_byte1  = d3_q[0][7:0];
            n_res.addr_byte2  = d3_q[0][15:8];
        end else if (sect[63:28] != '0) begin
            n_res.addr_mode   = atas_pkg::MODE_LBA48;
            n_res.device_head = n_res.device_head | atas_pkg::DEV_LBA;
            n_res.addr_byte0  = sect[7:0];
            n_res.addr_byte1  = sect[15:8];
            n_res.addr_byte2  = sect[23:16];
            n_res.addr_byte3  = sect[31:24];
            n_res.addr_byte4  = sect[39:32];
            n_res.addr_byte5  = sect[47:40];
        end else begin
            n_res.addr_mode   = atas_pkg::MODE_LBA28;
            n_res.device_head = n_res.device_head | atas_pkg::DEV_LBA
                                | {4'h0, sect[27:24]};
            n_res.addr_byte0  = sect[7:0];
            n_res.addr_byte1  = sect[15:8];
            n_res.addr_byte2  = sect[23:16];
        end
        if (n_res.addr_mode == atas_pkg::MODE_LBA48) begin
            n_res.command_byte = sb3_out.op ? atas_pkg::CMD_WRITE_EXT
                                            : atas_pkg::CMD_READ_EXT;
        end else begin
            n_res.command_byte = sb3_out.op ? atas_pkg::CMD_WRITE : atas_pkg::CMD_READ;
        end
        // errors clear everything but the status
        if (sb3_out.status != atas_pkg::ST_OK) begin
            n_res        = '0;
            n_res.status = sb3_out.status;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= d3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid   = r_ov;
    assign o_res.payload = r_res;

endmodule

FILE: design/atas_div.sv
// Pipelined restoring divider, one quotient bit per stage, shared divisor
// across lanes. Sideband bits travel with the valid bit.
module atas_div #(
    parameter int NW = 64,
    parameter int DW = 17,
    parameter int LN = 1,
    parameter int SW = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [LN-1:0][NW-1:0]  i_dividend,
    input  logic [DW-1:0]          i_divisor,
    input  logic [SW-1:0]          i_side,
    output logic                   o_valid,
    output logic [LN-1:0][NW-1:0]  o_quot,
    output logic [LN-1:0][DW-1:0]  o_rem,
    output logic [SW-1:0]          o_side
);

    logic [LN-1:0][DW-1:0] r_rem  [NW];
    logic [LN-1:0][NW-1:0] r_w    [NW];
    logic [SW-1:0]         r_side [NW];
    logic                  r_v    [NW];

    // One shift-subtract step: remainder in the top, quotient shifts in below
    function automatic logic [DW+NW-1:0] f_step(input logic [DW-1:0] rem,
                                                input logic [NW-1:0] w,
                                                input logic [DW-1:0] d);
        logic [DW:0] t;
        logic [DW:0] df;
        logic        ge;
        t  = {rem, w[NW-1]};
        df = t - {1'b0, d};
        ge = (t >= {1'b0, d});
        return {(ge ? df[DW-1:0] : t[DW-1:0]), w[NW-2:0], ge};
    endfunction

    for (genvar gk = 0; gk < NW; gk++) begin : g_stage
        logic [LN-1:0][DW-1:0] c_rem;
        logic [LN-1:0][NW-1:0] c_w;
        logic [SW-1:0]         c_side;
        logic                  c_v;

        if (gk == 0) begin : g_first
            assign c_rem  = '0;
            assign c_w    = i_dividend;
            assign c_side = i_side;
            assign c_v    = i_valid;
        end else begin : g_next
            assign c_rem  = r_rem[gk-1];
            assign c_w    = r_w[gk-1];
            assign c_side = r_side[gk-1];
            assign c_v    = r_v[gk-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gk] <= 1'b0;
            end else if (i_en) begin
                r_v[gk] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < LN; l++) begin
                    {r_rem[gk][l], r_w[gk][l]} <= f_step(c_rem[l], c_w[l], i_divisor);
                end
                r_side[gk] <= c_side;
            end
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_quot  = r_w[NW-1];
    assign o_rem   = r_rem[NW-1];
    assign o_side  = r_side[NW-1];

endmodule

FILE: design/atas_checker.sv
module atas_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [2:0] i_status,
    input logic [1:0] i_mode,
    input logic [7:0] i_cmd,
    input logic [7:0] i_dev,
    input logic [7:0] i_cnt,
    input logic [7:0] i_b0,
    input logic [7:0] i_b3,
    input logic [7:0] i_b4,
    input logic [7:0] i_b5
);

    // A stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result dropped while stalled");

    // Error results carry a zero mode, command, device/head, count and address byte 0
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status != atas_pkg::ST_OK |->
        i_mode == '0 && i_cmd == '0 && i_dev == '0 && i_cnt == '0 && i_b0 == '0)
        else $error("error result has non-zero fields");

    // Good results carry a known command with matching ext form
    a_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == atas_pkg::ST_OK |->
        ((i_mode == atas_pkg::MODE_LBA48) &&
         (i_cmd == atas_pkg::CMD_READ_EXT || i_cmd == atas_pkg::CMD_WRITE_EXT)) ||
        ((i_mode != atas_pkg::MODE_LBA48) &&
         (i_cmd == atas_pkg::CMD_READ || i_cmd == atas_pkg::CMD_WRITE)))
        else $error("bad command for mode");

    // Upper address bytes only in LBA48
    a_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_mode != atas_pkg::MODE_LBA48 |->
        i_b3 == '0 && i_b4 == '0 && i_b5 == '0)
        else $error("upper address bytes set outside LBA48");

    // Nothing offered straight after reset
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

endmodule

bind ata_taskfile_address_setup atas_checker u_atas_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_res.valid),
    .i_ready  (o_res.ready),
    .i_status (o_res.payload.status),
    .i_mode   (o_res.payload.addr_mode),
    .i_cmd    (o_res.payload.command_byte),
    .i_dev    (o_res.payload.device_head),
    .i_cnt    (o_res.payload.sector_count),
    .i_b0     (o_res.payload.addr_byte0),
    .i_b3     (o_res.payload.addr_byte3),
    .i_b4     (o_res.payload.addr_byte4),
    .i_b5     (o_res.payload.addr_byte5)
);
